// File: rtl/rational_arithmetic_unit_macros.svh
// Assertion macros used by the checker file (rtl/rau_checker.sv).
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Consequent must hold on the same clock edge as the antecedent.
`define RAU_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rau: assertion failed");

// Consequent must hold on the following clock edge.
`define RAU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rau: assertion failed");

`endif

// File: rtl/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int K_W           = $clog2(PROD_W);
  localparam int CMD_W         = 3;
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 31;

  typedef enum logic [CMD_W-1:0] {
    CMD_MUL = 3'd0,
    CMD_DIV = 3'd1,
    CMD_ADD = 3'd2,
    CMD_SUB = 3'd3,
    CMD_EQ  = 3'd4
  } cmd_e;

endpackage

// File: rtl/rational_arithmetic_unit.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    cmd_i, a_num_i, a_den_i, b_num_i, b_den_i
// out      out_valid_o / out_ready_i  res_num_o, res_den_o, is_equal_o, div_error_o
//
// Arithmetic: operands pass the shared multiplier, then the binary gcd (one
// compare/subtract or shift per step), then the divisions by the gcd.
// Cost is set by one shared 16x16 multiplier, the shared subtractor
// for gcd and two 32-step restoring divisions. Compare and unused codes skip all three.
// Reset clears the sequencer and the output valid; while a result stalls, the
// next one waits finished and the input stays held off.
module rational_arithmetic_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rau_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num_i,
  input  logic [rau_pkg::DEN_W-1:0]           a_den_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num_i,
  input  logic [rau_pkg::DEN_W-1:0]           b_den_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]       res_den_o,
  output logic                                is_equal_o,
  output logic                                div_error_o
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PREP, S_GCD, S_DIV, S_DONE
  } state_e;

  state_e                          state_q;
  logic [CMD_W-1:0]                cmd_q;
  logic signed [OPERAND_WIDTH-1:0] an_q, bn_q;
  logic [DEN_W-1:0]                ad_q, bd_q;
  logic [1:0]                      step_q;
  logic signed [PROD_W-1:0]        prod_q, n_q, d_q;
  logic                            neg_q;
  logic [PROD_W-1:0]               ga_q, gb_q, g_q, mn_q, md_q, q_q, rem_q;
  logic [K_W-1:0]                  k_q, cnt_q;
  logic                            pass_q;
  logic [PROD_W-1:0]               fin_mag_q;
  logic [RES_DEN_W-1:0]            fin_den_q;
  logic                            fin_eq_q, fin_err_q;
  logic                            out_valid_q, is_equal_q, div_error_q;
  logic signed [RES_NUM_W-1:0]     res_num_q;
  logic [RES_DEN_W-1:0]            res_den_q;

  logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
  logic signed [PROD_W-1:0]        mul_p;
  logic [PROD_W:0]                 sub_a, sub_b;
  logic [PROD_W+1:0]               sub_r;
  logic                            borrow, sub_zero;
  logic [PROD_W-1:0]               mag_n, mag_d, q_next;

  // Operand select for the shared multiplier, product index follows step_q.
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_x = an_q;
        mul_y = (cmd_q == CMD_MUL) ? bn_q : OPERAND_WIDTH'(bd_q);
      end
      2'd1: begin
        mul_x = OPERAND_WIDTH'(ad_q);
        mul_y = (cmd_q == CMD_MUL) ? OPERAND_WIDTH'(bd_q) : bn_q;
      end
      default: begin
        mul_x = OPERAND_WIDTH'(ad_q);
        mul_y = OPERAND_WIDTH'(bd_q);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  // Shared subtractor: gcd compare/subtract, or one restoring division step.
  always_comb begin
    if (state_q == S_DIV) begin
      sub_a = {rem_q, q_q[PROD_W-1]};
      sub_b = {1'b0, g_q};
    end else begin
      sub_a = {1'b0, ga_q};
      sub_b = {1'b0, gb_q};
    end
  end

  assign sub_r    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_r[PROD_W+1];
  assign sub_zero = (sub_r == '0);
  assign q_next   = {q_q[PROD_W-2:0], ~borrow};

  assign mag_n = n_q[PROD_W-1] ? PROD_W'(0) - PROD_W'(n_q) : PROD_W'(n_q);
  assign mag_d = d_q[PROD_W-1] ? PROD_W'(0) - PROD_W'(d_q) : PROD_W'(d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      an_q        <= '0;
      bn_q        <= '0;
      ad_q        <= '0;
      bd_q        <= '0;
      step_q      <= '0;
      prod_q      <= '0;
      n_q         <= '0;
      d_q         <= '0;
      neg_q       <= 1'b0;
      ga_q        <= '0;
      gb_q        <= '0;
      g_q         <= '0;
      mn_q        <= '0;
      md_q        <= '0;
      q_q         <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      fin_mag_q   <= '0;
      fin_den_q   <= '0;
      fin_eq_q    <= 1'b0;
      fin_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      res_num_q   <= '0;
      res_den_q   <= '0;
      is_equal_q  <= 1'b0;
      div_error_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= cmd_i;
            an_q      <= a_num_i;
            ad_q      <= a_den_i;
            bn_q      <= b_num_i;
            bd_q      <= b_den_i;
            step_q    <= '0;
            neg_q     <= 1'b0;
            fin_mag_q <= '0;
            fin_den_q <= RES_DEN_W'(1);
            fin_err_q <= 1'b0;
            fin_eq_q  <= 1'b0;
            unique case (cmd_i) inside
              CMD_MUL, CMD_DIV, CMD_ADD, CMD_SUB: state_q <= S_MUL;
              CMD_EQ: begin
                fin_eq_q <= (a_num_i == b_num_i) && (a_den_i == b_den_i);
                state_q  <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end

        S_MUL: begin
          prod_q <= mul_p;
          step_q <= step_q + 2'd1;
          case (step_q)
            2'd1: n_q <= prod_q;
            2'd2: begin
              if (cmd_q == CMD_MUL || cmd_q == CMD_DIV) begin
                d_q <= prod_q;
              end else if (cmd_q == CMD_ADD) begin
                n_q <= n_q + prod_q;
              end else begin
                n_q <= n_q - prod_q;
              end
            end
            2'd3: begin
              if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
                d_q <= prod_q;
              end
              state_q <= S_PREP;
            end
            default: ;
          endcase
        end

        S_PREP: begin
          neg_q <= n_q[PROD_W-1] ^ d_q[PROD_W-1];
          ga_q  <= mag_n;
          gb_q  <= mag_d;
          mn_q  <= mag_n;
          md_q  <= mag_d;
          k_q   <= '0;
          if (d_q == '0) begin
            neg_q     <= 1'b0;
            fin_err_q <= 1'b1;
            state_q   <= S_DONE;
          end else if (mag_n == '0) begin
            neg_q   <= 1'b0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_GCD;
          end
        end

        // Binary gcd, common factors of two counted in k_q.
        S_GCD: begin
          if (sub_zero) begin
            g_q     <= ga_q << k_q;
            q_q     <= mn_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= S_DIV;
          end else if (!ga_q[0] && !gb_q[0]) begin
            ga_q <= ga_q >> 1;
            gb_q <= gb_q >> 1;
            k_q  <= k_q + K_W'(1);
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (!borrow) begin
            ga_q <= sub_r[PROD_W-1:0];
          end else begin
            gb_q <= PROD_W'(0) - sub_r[PROD_W-1:0];
          end
        end

        // Numerator pass, then denominator pass, both divided by the gcd.
        S_DIV: begin
          q_q   <= q_next;
          rem_q <= borrow ? sub_a[PROD_W-1:0] : sub_r[PROD_W-1:0];
          cnt_q <= cnt_q + K_W'(1);
          if (cnt_q == K_W'(PROD_W - 1)) begin
            if (!pass_q) begin
              fin_mag_q <= q_next;
              q_q       <= md_q;
              rem_q     <= '0;
              cnt_q     <= '0;
              pass_q    <= 1'b1;
            end else begin
              fin_den_q <= q_next[RES_DEN_W-1:0];
              state_q   <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            res_num_q   <= neg_q ? RES_NUM_W'(PROD_W'(0) - fin_mag_q)
                                 : RES_NUM_W'(fin_mag_q);
            res_den_q   <= fin_den_q;
            is_equal_q  <= fin_eq_q;
            div_error_q <= fin_err_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign is_equal_o  = is_equal_q;
  assign div_error_o = div_error_q;

endmodule

// File: rtl/rau_checker.sv
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  input logic [rau_pkg::RES_DEN_W-1:0]        res_den_o,
  input logic                                 is_equal_o,
  input logic                                 div_error_o
);
  import rau_pkg::*;

  // Input side: a waiting item stays offered.
  `RAU_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i)

  // Output side: a stalled result holds.
  `RAU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(res_num_o) && $stable(res_den_o))

  // The unit is busy in the cycle after an input transfer.
  `RAU_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

  // A reduced denominator is never zero.
  `RAU_ASSERT_NOW(a_den_nonzero, out_valid_o, res_den_o != RES_DEN_W'(0))

  // Error and compare results carry 0/1 and never both flags.
  `RAU_ASSERT_NOW(a_flag_result, out_valid_o && (div_error_o || is_equal_o), res_num_o == RES_NUM_W'(0) && res_den_o == RES_DEN_W'(1) && !(div_error_o && is_equal_o))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
